[rtl/core/sha1_pkg.sv]
`default_nettype none

package sha1_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 5;

   localparam logic [31:0] H_INIT [HASH_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   localparam logic [6:0] ROUND_SCHED = 7'd16;
   localparam logic [6:0] ROUND_P1    = 7'd20;
   localparam logic [6:0] ROUND_P2    = 7'd40;
   localparam logic [6:0] ROUND_P3    = 7'd60;
   localparam logic [6:0] ROUND_LAST  = 7'd79;

   localparam logic [2:0] WORD_LAST   = 3'd4;
   localparam logic [5:0] POS_LAST    = 6'h3F;
   localparam logic [5:0] PAD_LEN_POS = 6'd56;
   localparam logic [7:0] BYTE_PAD    = 8'h80;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_ADD,
      S_PAD_START,
      S_PAD,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PAD_START,
      RET_PAD,
      RET_EMIT
   } ret_type;

   typedef struct packed {
      logic       absorb;
      logic       pad_start;
      logic       pad_write;
      logic       pad_wrap;
      logic       round_en;
      logic [6:0] round_idx;
      logic       chain_add;
      logic       reinit;
      logic [2:0] word_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pad_full;
      logic pad_final;
   } ctrl_status_type;

endpackage

`default_nettype wire

[rtl/core/sha1_dp.sv]
`default_nettype none

module sha1_dp
   import sha1_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      status,
   input  wire logic [7:0]      data_byte,
   output logic      [31:0]     digest_word
);

   logic [31:0] block_ff [BLOCK_WORDS];
   logic [31:0] block_in [BLOCK_WORDS];
   logic [31:0] chain_ff [HASH_WORDS];
   logic [31:0] chain_in [HASH_WORDS];
   logic [31:0] work_ff  [HASH_WORDS];
   logic [31:0] work_in  [HASH_WORDS];
   logic [63:0] count_ff;
   logic [63:0] count_in;
   logic [6:0]  pad_pos_ff;
   logic [6:0]  pad_pos_in;
   logic        pad_final_ff;
   logic        pad_final_in;

   logic        wr_en;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic [63:0] bit_len;
   logic [7:0]  len_byte;
   logic        len_sel;
   logic [31:0] sched_mix;
   logic [31:0] w_cur;
   logic [31:0] src [HASH_WORDS];
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;

   assign bit_len  = {count_ff[60:0], 3'b000};
   assign len_byte = bit_len[{~pad_pos_ff[2:0], 3'b000} +: 8];
   assign len_sel  = pad_final_ff && (pad_pos_ff[5:3] == PAD_LEN_POS[5:3]);
   assign wr_en    = cmd.absorb | cmd.pad_start | cmd.pad_write;
   assign wr_pos   = cmd.pad_write ? pad_pos_ff[5:0] : count_ff[5:0];

   always_comb begin
      if (cmd.absorb) begin
         wr_byte = data_byte;
      end else if (cmd.pad_start) begin
         wr_byte = BYTE_PAD;
      end else if (len_sel) begin
         wr_byte = len_byte;
      end else begin
         wr_byte = 8'h00;
      end
   end

   // message schedule runs in place over the block buffer
   assign sched_mix = block_ff[13] ^ block_ff[8] ^ block_ff[2] ^ block_ff[0];
   assign w_cur = (cmd.round_idx < ROUND_SCHED) ? block_ff[0]
                                                : {sched_mix[30:0], sched_mix[31]};

   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) begin
         src[i] = (cmd.round_idx == 7'd0) ? chain_ff[i] : work_ff[i];
      end
   end

   always_comb begin
      if (cmd.round_idx < ROUND_P1) begin
         f_val = src[3] ^ (src[1] & (src[2] ^ src[3]));
         k_val = K_R0;
      end else if (cmd.round_idx < ROUND_P2) begin
         f_val = src[1] ^ src[2] ^ src[3];
         k_val = K_R1;
      end else if (cmd.round_idx < ROUND_P3) begin
         f_val = (src[1] & src[2]) | (src[3] & (src[1] | src[2]));
         k_val = K_R2;
      end else begin
         f_val = src[1] ^ src[2] ^ src[3];
         k_val = K_R3;
      end
   end

   assign t_val = {src[0][26:0], src[0][31:27]} + f_val + src[4] + k_val + w_cur;

   always_comb begin
      block_in = block_ff;
      if (cmd.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            block_in[i] = block_ff[i + 1];
         end
         block_in[BLOCK_WORDS - 1] = w_cur;
      end else if (wr_en) begin
         block_in[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] = wr_byte;
      end
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.round_en) begin
         work_in[0] = t_val;
         work_in[1] = src[0];
         work_in[2] = {src[1][1:0], src[1][31:2]};
         work_in[3] = src[2];
         work_in[4] = src[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.reinit) begin
         chain_in = H_INIT;
      end else if (cmd.chain_add) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      pad_pos_in   = pad_pos_ff;
      pad_final_in = pad_final_ff;
      if (cmd.reinit) begin
         count_in = 64'd0;
      end else if (cmd.absorb) begin
         count_in = count_ff + 64'd1;
      end
      if (cmd.pad_start) begin
         pad_pos_in   = {1'b0, count_ff[5:0]} + 7'd1;
         pad_final_in = count_ff[5:0] < PAD_LEN_POS;
      end else if (cmd.pad_write) begin
         pad_pos_in = pad_pos_ff + 7'd1;
      end else if (cmd.pad_wrap) begin
         pad_pos_in   = 7'd0;
         pad_final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff     <= H_INIT;
         count_ff     <= 64'd0;
         pad_pos_ff   <= 7'd0;
         pad_final_ff <= 1'b0;
      end else begin
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         pad_pos_ff   <= pad_pos_in;
         pad_final_ff <= pad_final_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
   end

   assign status.pos_last  = count_ff[5:0] == POS_LAST;
   assign status.pad_full  = pad_pos_ff[6];
   assign status.pad_final = pad_final_ff;
   assign digest_word      = chain_ff[cmd.word_sel];

endmodule

`default_nettype wire

[rtl/core/sha1_ctrl.sv]
`default_nettype none

module sha1_ctrl
   import sha1_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic            byte_valid,
   input  wire logic            end_of_message,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   state_type  state_ff, state_in;
   ret_type    ret_ff, ret_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_IDLE;
         round_ff <= 7'd0;
         word_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.word_sel  = word_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.absorb = byte_valid;
               if (byte_valid && status.pos_last) begin
                  state_in = S_ROUND;
                  ret_in   = end_of_message ? RET_PAD_START : RET_IDLE;
               end else if (end_of_message) begin
                  state_in = S_PAD_START;
               end
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == ROUND_LAST) begin
               round_in = 7'd0;
               state_in = S_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         S_ADD: begin
            cmd.chain_add = 1'b1;
            case (ret_ff)
               RET_IDLE:      state_in = S_IDLE;
               RET_PAD_START: state_in = S_PAD_START;
               RET_PAD:       state_in = S_PAD;
               RET_EMIT: begin
                  state_in = S_EMIT;
                  word_in  = 3'd0;
               end
               default:       state_in = S_IDLE;
            endcase
         end
         S_PAD_START: begin
            cmd.pad_start = 1'b1;
            state_in      = S_PAD;
         end
         S_PAD: begin
            if (status.pad_full) begin
               state_in = S_ROUND;
               if (status.pad_final) begin
                  ret_in = RET_EMIT;
               end else begin
                  cmd.pad_wrap = 1'b1;
                  ret_in       = RET_PAD;
               end
            end else begin
               cmd.pad_write = 1'b1;
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (word_ff == WORD_LAST) begin
                  cmd.reinit = 1'b1;
                  word_in    = 3'd0;
                  state_in   = S_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/sha1_stream_hasher.sv]
`default_nettype none

// SHA-1 over a byte stream, one byte per request. The request that completes a 64-byte
// block is followed by a busy phase (80 rounds on a single shared round unit, then the
// chaining-word add). An end-of-message request starts padding, which writes the 0x80
// marker, zeros and the bit length one byte per cycle up to the block end, plus a step
// that sees the block full, with one compression per padded block, and a second padded
// block when the first has no room for the length. The five digest words then go out H0
// first, one per accepted response, the fifth with rsp_tlast, and the hasher is back at
// its initial state. req_tready is low whenever the block is busy.
module sha1_stream_hasher
   import sha1_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [0:0]  req_tuser,   // byte_valid
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // digest_word
   output logic      [2:0]  rsp_tuser,   // word_index
   output logic             rsp_tlast
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .byte_valid     (req_tuser[0]),
      .end_of_message (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .cmd            (cmd)
   );

   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_tdata),
      .digest_word (rsp_tdata)
   );

   assign rsp_tuser = cmd.word_sel;
   assign rsp_tlast = cmd.word_sel == WORD_LAST;

endmodule

`default_nettype wire

[rtl/core/sha1_checker.sv]
`default_nettype none

module sha1_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // no request taken while a digest is going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready during digest output");

   // digest words follow one another without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest word sequence broken");

   // last flag only on the fifth word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd4)))
      else $error("last flag on wrong word");

   // end of message always leads to padding work
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (!req_tready && !rsp_tvalid))
      else $error("no padding after end of message");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind sha1_stream_hasher sha1_checker u_checker (.*);

`default_nettype wire

[dv/sha1_digest_checker.sv]
module sha1_digest_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [0:0]  req_tuser,   // byte_valid
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // digest_word
   input  wire logic [2:0]  rsp_tuser,   // word_index
   input  wire logic        rsp_tlast,
   output int unsigned      failures,
   output int unsigned      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int unsigned DIGEST_LEN = 5;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain [DIGEST_LEN];
   logic [31:0]     block_buf [16];
   logic [63:0]     byte_count;
   digest_word_type digest_queue [$];

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   task automatic restart_hash();
      chain[0] = IV0;
      chain[1] = IV1;
      chain[2] = IV2;
      chain[3] = IV3;
      chain[4] = IV4;
      byte_count = '0;
   endtask

   task automatic store_byte(input int unsigned pos, input logic [7:0] v);
      block_buf[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = v;
   endtask

   task automatic compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
      for (int i = 16; i < 80; i++) begin
         sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = d ^ (b & (c ^ d));
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (d & (b | c));
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + sched[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endtask

   task automatic pad_and_finish();
      logic [63:0] bit_len;
      int unsigned pos;
      bit_len = byte_count << 3;
      pos = 32'(byte_count[5:0]);
      store_byte(pos, PAD_MARK);
      pos++;
      if (pos > 56) begin
         while (pos < 64) begin
            store_byte(pos, 8'h00);
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         store_byte(pos, 8'h00);
         pos++;
      end
      for (int i = 0; i < 8; i++) store_byte(56 + i, bit_len[8 * (7 - i) +: 8]);
      compress_block();
   endtask

   task automatic absorb_request(input logic [7:0] data, input logic valid, input logic fin);
      int unsigned pos;
      digest_word_type item;
      if (valid) begin
         pos = 32'(byte_count[5:0]);
         store_byte(pos, data);
         byte_count++;
         if (pos == 63) compress_block();
      end
      if (fin) begin
         pad_and_finish();
         for (int i = 0; i < DIGEST_LEN; i++) begin
            item.word  = chain[i];
            item.index = 3'(i);
            item.last  = (i == DIGEST_LEN - 1);
            digest_queue.push_back(item);
         end
         restart_hash();
      end
   endtask

   always @(posedge clock) begin : monitor
      digest_word_type want;
      if (reset) begin
         restart_hash();
         for (int i = 0; i < 16; i++) block_buf[i] = '0;
         digest_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               failures++;
               $error("digest word %h arrived with none expected", rsp_tdata);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_tdata !== want.word) begin
                  failures++;
                  $error("digest_word: expected %h, actual %h", want.word, rsp_tdata);
               end
               if (rsp_tuser !== want.index) begin
                  failures++;
                  $error("word_index: expected %0d, actual %0d", want.index, rsp_tuser);
               end
               if (rsp_tlast !== want.last) begin
                  failures++;
                  $error("last_word: expected %b, actual %b", want.last, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) absorb_request(req_tdata, req_tuser[0], req_tlast);
      end
      outstanding = digest_queue.size();
   end

endmodule

[dv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned RANDOM_ITEMS  = 350;
   localparam int unsigned DRAIN_CYCLES  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int unsigned request_count = 0;
   int unsigned send_idle = 29;
   int unsigned recv_idle = 65;

   sha1_stream_hasher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_digest_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sha1_stream_hasher: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send_request(input logic [7:0] data, input logic valid, input logic fin);
      if (valid || fin) request_count++;
      if (request_count < 120) begin
         send_idle = 29;
         recv_idle = 65;
      end else if (request_count < 240) begin
         send_idle = 65;
         recv_idle = 29;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= valid;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // for a nonempty message, the end request carries the final byte about half the time
   task automatic send_message(input int unsigned length);
      logic carry;
      carry = (length != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned n = 0; n < length; n++) begin
         if ($urandom_range(0, 99) < 8) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(0, 255)), 1'b1, carry && (n == length - 1));
      end
      if (!carry) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int unsigned boundary_lengths [10];
      int unsigned length;
      boundary_lengths = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_request(8'h00, 1'b0, 1'b1);
      // byte together with end
      send_request(8'hFF, 1'b1, 1'b1);
      // zero byte, then a bare end
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      // ignored requests before and within a short message
      send_request(8'hA5, 1'b0, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h5A, 1'b0, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      // bare end with nonzero data
      send_request(8'hFF, 1'b0, 1'b1);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7F, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);

      request_count = 0;
      while (request_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 12) length = boundary_lengths[$urandom_range(0, 9)];
         else length = $urandom_range(0, 20);
         send_message(length);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("sha1_stream_hasher: match");
      end else begin
         $display("sha1_stream_hasher: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sha1_pkg.sv
rtl/core/sha1_dp.sv
rtl/core/sha1_ctrl.sv
rtl/core/sha1_stream_hasher.sv
rtl/core/sha1_checker.sv
dv/sha1_digest_checker.sv
dv/testbench.sv
